/* design/scps_pkg.sv */
// scps_pkg: shared types, constants and fixed-point helpers for the S-curve sampler.
// Used by every module of the block except scps_mul; depends on nothing.
package scps_pkg;

  localparam int TIME_FRAC_BITS = 24;
  localparam int NUM_PHASES     = 7;
  localparam int LAST_EVAL      = NUM_PHASES - 2;
  localparam int PIPE_LAST      = 14;
  localparam int DIV6_SHIFT     = 66;

  localparam logic [61:0] WIDE_CAP   = '1;
  localparam logic [63:0] DIV6_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;

  localparam logic signed [63:0] POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] POS_MIN = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] VEL_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] VEL_MIN = 64'shFFFF_FF80_0000_0000;

  typedef enum logic [2:0] {
    REG_ACCEL_RAMP  = 3'd0,
    REG_ACCEL_HOLD  = 3'd1,
    REG_CRUISE      = 3'd2,
    REG_DECEL_RAMP  = 3'd3,
    REG_DECEL_HOLD  = 3'd4,
    REG_START_VEL   = 3'd5,
    REG_ACCEL_JERK  = 3'd6,
    REG_DECEL_JERK  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_ISSUE = 3'b010,
    SEQ_WAIT  = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic [6:0][34:0] start;
    logic [34:0]      pend;
    logic [6:0][40:0] jk;
    logic [6:0][49:0] a0;
    logic [6:0][39:0] v;
    logic [6:0][47:0] p;
  } tbl_t;

  typedef struct packed {
    logic [31:0] t;
    logic [2:0]  k;
    logic        oor;
  } qitem_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         k;
    logic [47:0]        pos;
    logic [39:0]        vel;
    logic signed [63:0] acc;
  } wb_t;

  typedef struct packed {
    logic               rec;
    logic [2:0]         k;
    logic               oor;
    logic [31:0]        u;
    logic signed [40:0] jk;
    logic signed [49:0] a0;
    logic signed [39:0] v;
    logic signed [47:0] p;
    logic [39:0]        u2;
    logic [47:0]        u3;
    logic signed [63:0] jku;
    logic signed [63:0] a0u;
    logic signed [63:0] vu;
    logic signed [63:0] acc;
    logic signed [63:0] vt;
    logic signed [63:0] s1;
    logic signed [63:0] jku2;
    logic signed [63:0] a0u2;
    logic signed [63:0] vel;
    logic [61:0]        ju3;
    logic signed [63:0] q;
    logic signed [63:0] pos2;
    logic signed [63:0] pos;
  } ctx_t;

  function automatic logic [61:0] mulq(input logic [127:0] prod, input logic extra);
    logic [127:0] sum;
    logic [127:0] shd;
    sum = prod + (extra ? (128'd1 << TIME_FRAC_BITS) : (128'd1 << (TIME_FRAC_BITS - 1)));
    shd = extra ? (sum >> (TIME_FRAC_BITS + 1)) : (sum >> TIME_FRAC_BITS);
    if (shd > {66'd0, WIDE_CAP}) return WIDE_CAP;
    return shd[61:0];
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({3'b000, WIDE_CAP})) return $signed({2'b00, WIDE_CAP});
    if (s < -$signed({3'b000, WIDE_CAP})) return -$signed({2'b00, WIDE_CAP});
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sgnw(input logic neg, input logic [61:0] mag);
    logic [63:0] m;
    m = {2'b00, mag};
    return $signed(neg ? (~m + 64'd1) : m);
  endfunction

  function automatic logic [63:0] absw(input logic signed [63:0] x);
    return $unsigned(x[63] ? -x : x);
  endfunction

  function automatic logic [47:0] clamp48(input logic signed [63:0] x);
    if (x > POS_MAX) return POS_MAX[47:0];
    if (x < POS_MIN) return POS_MIN[47:0];
    return x[47:0];
  endfunction

  function automatic logic [39:0] clamp40(input logic signed [63:0] x);
    if (x > VEL_MAX) return VEL_MAX[39:0];
    if (x < VEL_MIN) return VEL_MIN[39:0];
    return x[39:0];
  endfunction

endpackage

/* design/scps_mul.sv */
// scps_mul: 64x64 unsigned multiplier, four 32x32 partial products, two stages.
// Depends on nothing; advances only while en is high.
module scps_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod
);

  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [127:0] prod_r;
  logic [127:0] prod_nxt;

  assign prod_nxt = {64'd0, pp00_r} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0}
                  + {pp11_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= a[31:0]  * b[31:0];
      pp01_r <= a[31:0]  * b[63:32];
      pp10_r <= a[63:32] * b[31:0];
      pp11_r <= a[63:32] * b[63:32];
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

/* design/scps_tables.sv */
// scps_tables: configuration registers, phase tables and the sequencer that
// rebuilds phase start values through the back pipeline. Depends on scps_pkg.
module scps_tables import scps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  wb_t         wb,
  input  logic        rec_take,
  output tbl_t        tbl,
  output logic        rec_req,
  output logic [2:0]  rec_k,
  output logic [31:0] rec_u,
  output logic        busy,
  output logic        flush
);

  logic [31:0] accel_ramp_r, accel_hold_r, cruise_r, decel_ramp_r, decel_hold_r;
  logic [39:0] start_vel_r, accel_jerk_r, decel_jerk_r;
  logic [31:0] dur [0:NUM_PHASES-1];
  logic [34:0] st_nxt [0:NUM_PHASES];
  logic [34:0] start_r [0:NUM_PHASES-1];
  logic [34:0] pend_r;
  logic [39:0] vtab_r [1:NUM_PHASES-1];
  logic [47:0] ptab_r [1:NUM_PHASES-1];
  logic [49:0] pa_r, pdn_r;
  logic [39:0] v0;
  logic [40:0] ja, jd;
  seq_state_t  state_r, state_nxt;
  logic [2:0]  seq_k_r, seq_k_nxt;
  logic        wb_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_ramp_r <= '0;
      accel_hold_r <= '0;
      cruise_r     <= '0;
      decel_ramp_r <= '0;
      decel_hold_r <= '0;
      start_vel_r  <= '0;
      accel_jerk_r <= '0;
      decel_jerk_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACCEL_RAMP: accel_ramp_r <= cfg_data[31:0];
        REG_ACCEL_HOLD: accel_hold_r <= cfg_data[31:0];
        REG_CRUISE:     cruise_r     <= cfg_data[31:0];
        REG_DECEL_RAMP: decel_ramp_r <= cfg_data[31:0];
        REG_DECEL_HOLD: decel_hold_r <= cfg_data[31:0];
        REG_START_VEL:  start_vel_r  <= cfg_data;
        REG_ACCEL_JERK: accel_jerk_r <= cfg_data;
        REG_DECEL_JERK: decel_jerk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dur[0] = accel_ramp_r;
    dur[1] = accel_hold_r;
    dur[2] = accel_ramp_r;
    dur[3] = cruise_r;
    dur[4] = decel_ramp_r;
    dur[5] = decel_hold_r;
    dur[6] = decel_ramp_r;
    st_nxt[0] = '0;
    for (int i = 1; i <= NUM_PHASES; i++) begin
      st_nxt[i] = st_nxt[i-1] + {3'b000, dur[i-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PHASES; i++) start_r[i] <= '0;
      pend_r <= '0;
    end else begin
      for (int i = 0; i < NUM_PHASES; i++) start_r[i] <= st_nxt[i];
      pend_r <= st_nxt[NUM_PHASES];
    end
  end

  assign v0 = start_vel_r[39] ? VEL_MAX[39:0] : start_vel_r;
  assign ja = {1'b0, accel_jerk_r};
  assign jd = {1'b0, decel_jerk_r};

  always_comb begin
    tbl.pend  = pend_r;
    tbl.jk[0] = ja;
    tbl.jk[1] = '0;
    tbl.jk[2] = -ja;
    tbl.jk[3] = '0;
    tbl.jk[4] = -jd;
    tbl.jk[5] = '0;
    tbl.jk[6] = jd;
    tbl.a0[0] = '0;
    tbl.a0[1] = pa_r;
    tbl.a0[2] = pa_r;
    tbl.a0[3] = '0;
    tbl.a0[4] = '0;
    tbl.a0[5] = pdn_r;
    tbl.a0[6] = pdn_r;
    tbl.v[0]  = v0;
    tbl.p[0]  = '0;
    for (int i = 0; i < NUM_PHASES; i++) tbl.start[i] = start_r[i];
    for (int i = 1; i < NUM_PHASES; i++) begin
      tbl.v[i] = vtab_r[i];
      tbl.p[i] = ptab_r[i];
    end
  end

  assign wb_take = (state_r == SEQ_WAIT) && wb.valid && !cfg_we;

  always_comb begin
    state_nxt = state_r;
    seq_k_nxt = seq_k_r;
    unique case (state_r)
      SEQ_IDLE: ;
      SEQ_ISSUE: begin
        if (rec_take) state_nxt = SEQ_WAIT;
      end
      SEQ_WAIT: begin
        if (wb.valid) begin
          if (seq_k_r == 3'(LAST_EVAL)) begin
            state_nxt = SEQ_IDLE;
          end else begin
            seq_k_nxt = seq_k_r + 3'd1;
            state_nxt = SEQ_ISSUE;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = SEQ_ISSUE;
      seq_k_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      seq_k_r <= '0;
      pa_r    <= '0;
      pdn_r   <= '0;
      for (int i = 1; i < NUM_PHASES; i++) begin
        vtab_r[i] <= '0;
        ptab_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      seq_k_r <= seq_k_nxt;
      if (wb_take) begin
        for (int i = 1; i < NUM_PHASES; i++) begin
          if (seq_k_r == 3'(i - 1)) begin
            vtab_r[i] <= wb.vel;
            ptab_r[i] <= wb.pos;
          end
        end
        if (seq_k_r == 3'd0) pa_r <= wb.acc[49:0];
        if (seq_k_r == 3'd4) pdn_r <= wb.acc[49:0];
      end
    end
  end

  assign rec_req = (state_r == SEQ_ISSUE);
  assign rec_k   = seq_k_r;
  assign rec_u   = dur[seq_k_r];
  assign busy    = (state_r != SEQ_IDLE);
  assign flush   = cfg_we;

endmodule

/* design/scps_front.sv */
// scps_front: takes sample requests, finds the phase and the end-of-profile flag,
// and holds them in a two-entry queue for the back pipeline. Depends on scps_pkg.
module scps_front import scps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_time,
  input  tbl_t        tbl,
  input  logic        busy,
  input  logic        cfg_we,
  input  logic        pop,
  output logic        q_valid,
  output qitem_t      q_item
);

  qitem_t      ent_r [0:1];
  qitem_t      cls;
  logic        rd_r, wr_r;
  logic [1:0]  cnt_r;
  logic        push;

  always_comb begin
    cls.t   = in_sample_time;
    cls.oor = ({3'b000, in_sample_time} >= tbl.pend);
    cls.k   = '0;
    for (int i = 1; i < NUM_PHASES; i++) begin
      if (tbl.start[i] <= {3'b000, in_sample_time}) cls.k = 3'(i);
    end
  end

  assign in_stall = (cnt_r == 2'd2) || busy || cfg_we;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/scps_back.sv */
// scps_back: pipelined phase polynomial evaluator with output register.
// Depends on scps_pkg and scps_mul; also runs the table rebuild evaluations.
module scps_back import scps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  qitem_t             q_item,
  output logic               pop,
  input  logic               rec_req,
  input  logic [2:0]         rec_k,
  input  logic [31:0]        rec_u,
  output logic               rec_take,
  input  logic               flush,
  input  tbl_t               tbl,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_position,
  output logic signed [39:0] out_velocity,
  output logic signed [39:0] out_acceleration,
  output logic signed [40:0] out_jerk_now,
  output logic [2:0]         out_phase,
  output logic               out_out_of_range,
  output wb_t                wb
);

  ctx_t  ctx_r   [0:PIPE_LAST];
  ctx_t  ctx_nxt [0:PIPE_LAST];
  logic [PIPE_LAST:0] vld_r, vld_nxt, kill_nxt, kill_cur;
  logic  en;
  logic [2:0]  k0;
  logic [34:0] st0;
  logic [127:0] p_uu, p_ju, p_au, p_vu, p_u3, p_ju2, p_au2, p_ju3, p_d6;
  logic [63:0] jkm0, a0m0, vm0, jkm3, a0m3, jkm6;
  logic        out_valid_r;
  logic signed [47:0] out_position_r;
  logic signed [39:0] out_velocity_r, out_acceleration_r;
  logic signed [40:0] out_jerk_now_r;
  logic [2:0]  out_phase_r;
  logic        out_oor_r;

  assign en       = !out_valid_r || !out_stall;
  assign rec_take = en && rec_req;
  assign pop      = en && !rec_req && q_valid;

  assign jkm0 = absw({{23{ctx_r[0].jk[40]}}, ctx_r[0].jk});
  assign a0m0 = absw({{14{ctx_r[0].a0[49]}}, ctx_r[0].a0});
  assign vm0  = absw({{24{ctx_r[0].v[39]}}, ctx_r[0].v});
  assign jkm3 = absw({{23{ctx_r[3].jk[40]}}, ctx_r[3].jk});
  assign a0m3 = absw({{14{ctx_r[3].a0[49]}}, ctx_r[3].a0});
  assign jkm6 = absw({{23{ctx_r[6].jk[40]}}, ctx_r[6].jk});

  scps_mul u_m_uu  (.clk, .en, .a({32'd0, ctx_r[0].u}), .b({32'd0, ctx_r[0].u}), .prod(p_uu));
  scps_mul u_m_ju  (.clk, .en, .a(jkm0), .b({32'd0, ctx_r[0].u}), .prod(p_ju));
  scps_mul u_m_au  (.clk, .en, .a(a0m0), .b({32'd0, ctx_r[0].u}), .prod(p_au));
  scps_mul u_m_vu  (.clk, .en, .a(vm0),  .b({32'd0, ctx_r[0].u}), .prod(p_vu));
  scps_mul u_m_u3  (.clk, .en, .a({24'd0, ctx_r[3].u2}), .b({32'd0, ctx_r[3].u}),
                    .prod(p_u3));
  scps_mul u_m_ju2 (.clk, .en, .a(jkm3), .b({24'd0, ctx_r[3].u2}), .prod(p_ju2));
  scps_mul u_m_au2 (.clk, .en, .a(a0m3), .b({24'd0, ctx_r[3].u2}), .prod(p_au2));
  scps_mul u_m_ju3 (.clk, .en, .a(jkm6), .b({16'd0, ctx_r[6].u3}), .prod(p_ju3));
  scps_mul u_m_d6  (.clk, .en, .a({2'b00, ctx_r[9].ju3} + 64'd3), .b(DIV6_MAGIC),
                    .prod(p_d6));

  assign k0  = rec_req ? rec_k : q_item.k;
  assign st0 = tbl.start[k0];

  always_comb begin
    ctx_nxt[0]     = '0;
    ctx_nxt[0].rec = rec_req;
    ctx_nxt[0].k   = k0;
    ctx_nxt[0].oor = rec_req ? 1'b0 : q_item.oor;
    ctx_nxt[0].u   = rec_req ? rec_u : (q_item.t - st0[31:0]);
    ctx_nxt[0].jk  = tbl.jk[k0];
    ctx_nxt[0].a0  = tbl.a0[k0];
    ctx_nxt[0].v   = tbl.v[k0];
    ctx_nxt[0].p   = tbl.p[k0];
    vld_nxt[0]     = rec_req || q_valid;
    for (int i = 1; i <= PIPE_LAST; i++) begin
      ctx_nxt[i] = ctx_r[i-1];
      vld_nxt[i] = vld_r[i-1];
    end
    ctx_nxt[3].u2   = 40'(mulq(p_uu, 1'b0));
    ctx_nxt[3].jku  = sgnw(ctx_r[2].jk[40], mulq(p_ju, 1'b0));
    ctx_nxt[3].a0u  = sgnw(ctx_r[2].a0[49], mulq(p_au, 1'b0));
    ctx_nxt[3].vu   = sgnw(ctx_r[2].v[39], mulq(p_vu, 1'b0));
    ctx_nxt[4].acc  = sadd({{14{ctx_r[3].a0[49]}}, ctx_r[3].a0}, ctx_r[3].jku);
    ctx_nxt[4].vt   = sadd({{24{ctx_r[3].v[39]}}, ctx_r[3].v}, ctx_r[3].a0u);
    ctx_nxt[4].s1   = sadd({{16{ctx_r[3].p[47]}}, ctx_r[3].p}, ctx_r[3].vu);
    ctx_nxt[6].u3   = 48'(mulq(p_u3, 1'b0));
    ctx_nxt[6].jku2 = sgnw(ctx_r[5].jk[40], mulq(p_ju2, 1'b1));
    ctx_nxt[6].a0u2 = sgnw(ctx_r[5].a0[49], mulq(p_au2, 1'b1));
    ctx_nxt[7].vel  = sadd(ctx_r[6].vt, ctx_r[6].jku2);
    ctx_nxt[9].ju3  = mulq(p_ju3, 1'b0);
    ctx_nxt[12].q   = sgnw(ctx_r[11].jk[40], {1'b0, p_d6[DIV6_SHIFT+60:DIV6_SHIFT]});
    ctx_nxt[13].pos2 = sadd(ctx_r[12].a0u2, ctx_r[12].q);
    ctx_nxt[14].pos  = sadd(ctx_r[13].s1, ctx_r[13].pos2);
    for (int i = 0; i <= PIPE_LAST; i++) begin
      kill_nxt[i] = flush && ctx_nxt[i].rec;
      kill_cur[i] = flush && ctx_r[i].rec;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= PIPE_LAST; i++) ctx_r[i] <= ctx_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt & ~kill_nxt;
    end else begin
      vld_r <= vld_r & ~kill_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE_LAST] && !ctx_r[PIPE_LAST].rec;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctx_r[PIPE_LAST].oor) begin
        out_position_r     <= '0;
        out_velocity_r     <= '0;
        out_acceleration_r <= '0;
        out_jerk_now_r     <= '0;
        out_phase_r        <= '0;
      end else begin
        out_position_r     <= clamp48(ctx_r[PIPE_LAST].pos);
        out_velocity_r     <= clamp40(ctx_r[PIPE_LAST].vel);
        out_acceleration_r <= clamp40(ctx_r[PIPE_LAST].acc);
        out_jerk_now_r     <= ctx_r[PIPE_LAST].jk;
        out_phase_r        <= ctx_r[PIPE_LAST].k;
      end
      out_oor_r <= ctx_r[PIPE_LAST].oor;
    end
  end

  assign wb.valid = vld_r[PIPE_LAST] && ctx_r[PIPE_LAST].rec && en;
  assign wb.k     = ctx_r[PIPE_LAST].k;
  assign wb.pos   = clamp48(ctx_r[PIPE_LAST].pos);
  assign wb.vel   = clamp40(ctx_r[PIPE_LAST].vel);
  assign wb.acc   = ctx_r[PIPE_LAST].acc;

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_velocity     = out_velocity_r;
  assign out_acceleration = out_acceleration_r;
  assign out_jerk_now     = out_jerk_now_r;
  assign out_phase        = out_phase_r;
  assign out_out_of_range = out_oor_r;

endmodule

/* design/scurve_profile_sampler.sv */
// scurve_profile_sampler: top level of the seven-phase S-curve profile sampler.
// Depends on scps_pkg, scps_front, scps_back, scps_tables and scps_mul.
//
//   port group | direction | handshake          | contents
//   in_*       | input     | in_valid/in_stall   | sample_time request
//   out_*      | output    | out_valid/out_stall | position, velocity, accel, jerk, phase
//   cfg_*      | input     | cfg_we              | register index and data
//
// One request per cycle while in_stall is low; each request passes through the front queue
// and the back pipeline (four chained 64x64 multiplies plus rounding) to the output register.
// rst_n is synchronous; reset leaves all tables at zero, matching an all-zero profile.
// A config write holds in_stall while six phase evaluations,
// one after another, rebuild the start velocities and positions.
// out_stall freezes the whole back pipeline while out_valid is high; the front queue still fills up to two entries.
module scurve_profile_sampler import scps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_position,
  output logic signed [39:0] out_velocity,
  output logic signed [39:0] out_acceleration,
  output logic signed [40:0] out_jerk_now,
  output logic [2:0]         out_phase,
  output logic               out_out_of_range,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [39:0]        cfg_data
);

  tbl_t        tbl;
  wb_t         wb;
  qitem_t      q_item;
  logic        q_valid, pop;
  logic        rec_req, rec_take, busy, flush;
  logic [2:0]  rec_k;
  logic [31:0] rec_u;

  scps_tables u_tables (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .wb, .rec_take, .tbl, .rec_req, .rec_k, .rec_u, .busy, .flush
  );

  scps_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample_time,
    .tbl, .busy, .cfg_we, .pop, .q_valid, .q_item
  );

  scps_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .pop,
    .rec_req, .rec_k, .rec_u, .rec_take, .flush, .tbl,
    .out_valid, .out_stall, .out_position, .out_velocity, .out_acceleration,
    .out_jerk_now, .out_phase, .out_out_of_range, .wb
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for scurve_profile_sampler; predicts each profile sample in-line
// or takes a supplied expected frame, and compares every result field. Depends on scps_pkg and the block's RTL.
module tb;
  import scps_pkg::*;

  localparam logic [63:0] CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int LIMIT = 400000;
  localparam logic [31:0] SEC = 32'h0100_0000;

  typedef struct {
    logic [47:0] pos;
    logic [39:0] vel;
    logic [39:0] acc;
    logic [40:0] jerk;
    logic [2:0]  phase;
    logic        oor;
  } frame_t;

  typedef struct {
    logic [31:0] t;
    logic        typed;
    frame_t      frame;
  } request_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_sample_time = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [47:0] out_position;
  logic signed [39:0] out_velocity;
  logic signed [39:0] out_acceleration;
  logic signed [40:0] out_jerk_now;
  logic [2:0] out_phase;
  logic out_out_of_range;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;

  scurve_profile_sampler i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // profile registers and derived phase tables
  logic [63:0] prof_reg [8];
  logic [63:0] ph_start [7];
  longint ph_vel [7];
  longint ph_pos [7];
  longint ph_acc0 [7];
  longint ph_jerk [7];
  logic [63:0] prof_end;

  request_t sample_q[$];
  frame_t expected_frames[$];
  request_t cur;
  int gap_left = 0;
  bit gaps_on = 1;
  bit stalls_on = 1;
  int long_hold = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic logic [63:0] rmul(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > {64'd0, CAP}) return CAP;
    return p[63:0];
  endfunction

  function automatic longint smul(longint v, logic [63:0] m, int sh);
    logic [63:0] r;
    r = rmul(v < 0 ? 64'(-v) : 64'(v), m, sh);
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sdiv6(longint v);
    logic [63:0] r;
    r = ((v < 0 ? 64'(-v) : 64'(v)) + 64'd3) / 64'd6;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint ssum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > longint'(CAP)) return longint'(CAP);
    if (s < -longint'(CAP)) return -longint'(CAP);
    return s;
  endfunction

  function automatic longint clampw(longint x, int w);
    longint lim;
    lim = (longint'(1) <<< (w - 1)) - 1;
    if (x > lim) return lim;
    if (x < -lim - 1) return -lim - 1;
    return x;
  endfunction

  function automatic void eval_phase(int k, logic [63:0] u, output longint p,
                                     output longint v, output longint a);
    logic [63:0] u2, u3;
    u2 = rmul(u, u, TIME_FRAC_BITS);
    u3 = rmul(u2, u, TIME_FRAC_BITS);
    a = ssum(ph_acc0[k], smul(ph_jerk[k], u, TIME_FRAC_BITS));
    v = ssum(ssum(ph_vel[k], smul(ph_acc0[k], u, TIME_FRAC_BITS)),
             smul(ph_jerk[k], u2, TIME_FRAC_BITS + 1));
    p = ssum(ssum(ph_pos[k], smul(ph_vel[k], u, TIME_FRAC_BITS)),
             ssum(smul(ph_acc0[k], u2, TIME_FRAC_BITS + 1),
                  sdiv6(smul(ph_jerk[k], u3, TIME_FRAC_BITS))));
  endfunction

  task automatic rebuild_tables();
    logic [63:0] dur [7];
    longint pa, pd, p, v, a;
    dur[0] = prof_reg[REG_ACCEL_RAMP]; dur[1] = prof_reg[REG_ACCEL_HOLD];
    dur[2] = prof_reg[REG_ACCEL_RAMP]; dur[3] = prof_reg[REG_CRUISE];
    dur[4] = prof_reg[REG_DECEL_RAMP]; dur[5] = prof_reg[REG_DECEL_HOLD];
    dur[6] = prof_reg[REG_DECEL_RAMP];
    pa = longint'(rmul(prof_reg[REG_ACCEL_JERK], prof_reg[REG_ACCEL_RAMP], TIME_FRAC_BITS));
    pd = longint'(rmul(prof_reg[REG_DECEL_JERK], prof_reg[REG_DECEL_RAMP], TIME_FRAC_BITS));
    ph_acc0 = '{0, pa, pa, 0, 0, -pd, -pd};
    ph_jerk = '{longint'(prof_reg[REG_ACCEL_JERK]), 0, -longint'(prof_reg[REG_ACCEL_JERK]), 0,
                -longint'(prof_reg[REG_DECEL_JERK]), 0, longint'(prof_reg[REG_DECEL_JERK])};
    ph_start[0] = 0;
    for (int k = 1; k < 7; k++) ph_start[k] = ph_start[k - 1] + dur[k - 1];
    prof_end = ph_start[6] + dur[6];
    ph_pos[0] = 0;
    ph_vel[0] = clampw(longint'(prof_reg[REG_START_VEL]), 40);
    for (int k = 0; k < 6; k++) begin
      eval_phase(k, dur[k], p, v, a);
      ph_pos[k + 1] = clampw(p, 48);
      ph_vel[k + 1] = clampw(v, 40);
    end
  endtask

  function automatic frame_t sample_profile(logic [31:0] t);
    frame_t f;
    longint p, v, a;
    int k;
    f = '{default: '0};
    if ({32'd0, t} >= prof_end) begin
      f.oor = 1;
      return f;
    end
    k = 0;
    for (int i = 1; i < 7; i++) if (ph_start[i] <= {32'd0, t}) k = i;
    eval_phase(k, {32'd0, t} - ph_start[k], p, v, a);
    f.pos = 48'(clampw(p, 48));
    f.vel = 40'(clampw(v, 40));
    f.acc = 40'(clampw(a, 40));
    f.jerk = 41'(ph_jerk[k]);
    f.phase = 3'(k);
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    frame_t f;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        f = cur.typed ? cur.frame : sample_profile(cur.t);
        expected_frames = {expected_frames, f};
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 0;
          gap_left--;
        end else if (sample_q.size() > 0) begin
          cur = sample_q.pop_front();
          in_valid <= 1;
          in_sample_time <= cur.t;
          gap_left = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    frame_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with nothing expected");
      end else begin
        e = expected_frames.pop_front();
        if (out_position !== e.pos || out_velocity !== e.vel || out_acceleration !== e.acc ||
            out_jerk_now !== e.jerk || out_phase !== e.phase || out_out_of_range !== e.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tb: mismatch exp p=%h v=%h a=%h j=%h k=%0d o=%b",
                      " got p=%h v=%h a=%h j=%h k=%0d o=%b"},
                     e.pos, e.vel, e.acc, e.jerk, e.phase, e.oor, out_position, out_velocity,
                     out_acceleration, out_jerk_now, out_phase, out_out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold > 0) begin
      out_stall <= 1;
      long_hold--;
    end else if (stalls_on) begin
      out_stall <= pick_gap() != 0;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic wait_drained();
    while (sample_q.size() > 0 || in_valid || expected_frames.size() > 0) @(negedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_profile(logic [63:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= vals[i][39:0];
      prof_reg[i] = (i < REG_START_VEL) ? {32'd0, vals[i][31:0]} : {24'd0, vals[i][39:0]};
    end
    @(posedge clk);
    cfg_we <= 0;
    rebuild_tables();
  endtask

  task automatic queue_sample(logic [31:0] t, logic typed, frame_t f);
    request_t r;
    r.t = t;
    r.typed = typed;
    r.frame = f;
    sample_q = {sample_q, r};
  endtask

  task automatic queue_random(int n);
    logic [63:0] span;
    int r, k;
    logic [31:0] t;
    span = prof_end > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : prof_end;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 6);
      if (r < 80) t = $urandom_range(0, span[31:0]);
      else if (r < 90) t = $urandom;
      else t = ph_start[k][31:0] + $urandom_range(0, 2) - 1;
      queue_sample(t, 0, '{default: '0});
    end
  endtask

  initial begin
    frame_t oor_frame;
    frame_t none;
    logic [63:0] vals [8];
    logic [31:0] row_t [12];
    logic row_oor [12];
    oor_frame = '{default: '0};
    oor_frame.oor = 1;
    none = '{default: '0};
    for (int i = 0; i < 8; i++) prof_reg[i] = 0;
    rebuild_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // all-zero profile: every sample is past the end
    queue_sample(32'd0, 1, oor_frame);
    queue_sample(32'd1, 1, oor_frame);
    queue_sample(32'hFFFF_FFFF, 1, oor_frame);
    wait_drained();

    // directed profile with an empty decel hold phase
    vals = '{SEC, SEC / 2, SEC, SEC, 0, 64'd10 << 16, 64'd5 << 16, 64'd7 << 16};
    write_profile(vals);
    row_t = '{0, SEC - 1, SEC, SEC + SEC / 2, 5 * SEC / 2, 7 * SEC / 2, 9 * SEC / 2 - 1,
              9 * SEC / 2, 11 * SEC / 2 - 1, 11 * SEC / 2, 32'hFFFF_FFFF, 32'h8000_0000};
    row_oor = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1};
    foreach (row_t[i]) queue_sample(row_t[i], row_oor[i], row_oor[i] ? oor_frame : none);
    wait_drained();

    for (int s = 0; s < 7; s++) begin
      case (s)
        0: vals = '{64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF,
                    64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF};
        1: vals = '{0, 0, 0, 0, 0, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF};
        2: vals = '{0, SEC, SEC, 0, SEC, 64'd1 << 20, 64'd1 << 18, 64'd1 << 18};
        3: vals = '{1, 1, 1, 1, 1, 1, 1, 1};
        default: begin
          for (int i = 0; i < 5; i++) vals[i] = $urandom_range(0, SEC * 4);
          for (int i = 5; i < 8; i++) vals[i] = {$urandom, $urandom} & 64'hFF_FFFF_FFFF
                                                >> $urandom_range(0, 39);
        end
      endcase
      write_profile(vals);
      gaps_on = s != 2;
      stalls_on = s != 3;
      queue_random(70);
      if (s == 4) begin
        @(negedge clk);
        long_hold = 300;
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
